/* rtl/weighted_random_selector_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the weighted random selector
// Shared concurrent check forms, clocked on clk and quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_RANDOM_SELECTOR_CORE_ASSERT_SVH
`define WEIGHTED_RANDOM_SELECTOR_CORE_ASSERT_SVH

// Same-cycle implication check
`define WRS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define WRS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wrs_pkg.sv */
// ----------------------------------------------------------------------------
// wrs_pkg
// Request, status and register codes, field widths and the sequencer state
// type of the weighted random selector.
// ----------------------------------------------------------------------------
package wrs_pkg;

  // Fixed field widths
  localparam int REQ_W       = 2;
  localparam int IDX_IN_W    = 4;
  localparam int WEIGHT_IO_W = 16;
  localparam int RND_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 5;
  localparam int COUNT_W     = 5;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CHOOSE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTED_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC_MODE  = 2'd2;

  // A halved weight at or below this triggers the doubling pass
  localparam int LOW_LIMIT = 2;

  // Sequencer states
  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_RD       = 10'b00_0000_0010,
    S_SUM      = 10'b00_0000_0100,
    S_MUL_LO   = 10'b00_0000_1000,
    S_MUL_HI   = 10'b00_0001_0000,
    S_SCAN     = 10'b00_0010_0000,
    S_HALVE_RD = 10'b00_0100_0000,
    S_HALVE_WR = 10'b00_1000_0000,
    S_DBL      = 10'b01_0000_0000,
    S_DONE     = 10'b10_0000_0000
  } state_t;

endpackage

/* rtl/wrs_ram.sv */
// ----------------------------------------------------------------------------
// wrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. A read at the address being written returns the old data.
// ----------------------------------------------------------------------------
module wrs_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/weighted_random_selector_core.sv */
// ----------------------------------------------------------------------------
// weighted_random_selector_core: roulette wheel selection over a weight RAM
// One request at a time. Load goes via S_DONE, read via S_RD and S_DONE, to
// the result register. Weighted choose runs S_SUM, S_MUL_LO, S_MUL_HI and
// S_SCAN; the weight RAM read port streams one entry a cycle. Uniform choose
// skips S_SUM and S_SCAN. Dynamic mode then halves the pick, doubling if low.
// Synchronous active-low reset clears control and config; weights need loads.
// ----------------------------------------------------------------------------
`include "weighted_random_selector_core_assert.svh"

module weighted_random_selector_core
  import wrs_pkg::*;
#(
  parameter int MAX_ITEMS   = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // request channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [REQ_W-1:0]       in_req_type,
  input  logic [IDX_IN_W-1:0]    in_item_index,
  input  logic [WEIGHT_IO_W-1:0] in_weight_value,
  input  logic [RND_W-1:0]       in_random_fraction,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [IDX_IN_W-1:0]    out_chosen_index,
  output logic [WEIGHT_IO_W-1:0] out_weight_out,
  output logic [STATUS_W-1:0]    out_status
);

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int AX_W   = (CNT_W > IDX_IN_W) ? CNT_W : IDX_IN_W;
  localparam int TOT_W  = WEIGHT_BITS + CNT_W;
  localparam int TOTE_W = (TOT_W > RND_W) ? TOT_W : RND_W + 1;
  localparam int HI_W   = TOTE_W - RND_W;
  localparam int PS_W   = RND_W + HI_W + 1;

  // Configuration registers
  logic [COUNT_W-1:0] item_count_r;
  logic               weighted_mode_r;
  logic               dynamic_mode_r;

  // Sequencer and datapath registers
  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       iss_cnt_r, iss_cnt_nxt;
  logic                   rv_r, rv_nxt;
  logic [IDX_W-1:0]       ridx_r, ridx_nxt;
  logic [RND_W-1:0]       rnd_r, rnd_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [2*RND_W-1:0]     prod_r, prod_nxt;
  logic [TOT_W-1:0]       point_r, point_nxt;
  logic [TOT_W-1:0]       run_r, run_nxt;
  logic [IDX_W-1:0]       chosen_r, chosen_nxt;
  logic [REQ_W-1:0]       req_r, req_nxt;
  logic [IDX_IN_W-1:0]    res_chosen_r, res_chosen_nxt;
  logic [WEIGHT_IO_W-1:0] res_weight_r, res_weight_nxt;
  logic [STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [IDX_IN_W-1:0]    out_chosen_r, out_chosen_nxt;
  logic [WEIGHT_IO_W-1:0] out_weight_r, out_weight_nxt;
  logic [STATUS_W-1:0]    out_status_r, out_status_nxt;

  // RAM port signals
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [WEIGHT_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [WEIGHT_BITS-1:0] ram_rdata;

  // Combinational helpers
  logic [CMP_W-1:0]       cnt_ext;
  logic [CNT_W-1:0]       n_eff;
  logic [AX_W-1:0]        idx_ext;
  logic                   idx_oor;
  logic                   in_fire;
  logic                   scan_state;
  logic                   last_data;
  logic [TOTE_W-1:0]      total_ext;
  logic [HI_W-1:0]        total_hi;
  logic [RND_W+HI_W-1:0]  mul_hi;
  logic [PS_W-1:0]        point_sum;
  logic [TOT_W-1:0]       run_sum;
  logic [WEIGHT_BITS-1:0] half_w;
  logic [WEIGHT_BITS-1:0] dbl_w;

  // Check terms
  logic                   chk_read_only;
  logic                   chk_pick_done;
  logic                   chk_empty_req;
  logic                   chk_empty_done;

  wrs_ram #(
    .DATA_W (WEIGHT_BITS),
    .DEPTH  (MAX_ITEMS)
  ) u_weight_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Clamp the item count to the table size
  assign cnt_ext = CMP_W'(item_count_r);
  assign n_eff   = (cnt_ext > CMP_W'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : CNT_W'(cnt_ext);

  // Request index range check
  assign idx_ext = AX_W'(in_item_index);
  assign idx_oor = (idx_ext >= AX_W'(MAX_ITEMS));

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Streaming scan bookkeeping
  assign scan_state = (state_r == S_SUM) || (state_r == S_SCAN) || (state_r == S_DBL);
  assign last_data  = rv_r && (CNT_W'(ridx_r) == n_eff - CNT_W'(1));

  // Scale point = (rnd * total) >> 32, low word product then high word
  assign total_ext = TOTE_W'(total_r);
  assign total_hi  = total_ext[TOTE_W-1:RND_W];
  assign mul_hi    = rnd_r * total_hi;
  assign point_sum = PS_W'(mul_hi) + PS_W'(prod_r[2*RND_W-1:RND_W]);

  assign run_sum = run_r + TOT_W'(ram_rdata);
  assign half_w  = ram_rdata >> 1;
  assign dbl_w   = ram_rdata[WEIGHT_BITS-1] ? {WEIGHT_BITS{1'b1}}
                                            : {ram_rdata[WEIGHT_BITS-2:0], 1'b0};

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    iss_cnt_nxt    = iss_cnt_r;
    rv_nxt         = 1'b0;
    ridx_nxt       = ridx_r;
    rnd_nxt        = rnd_r;
    total_nxt      = total_r;
    prod_nxt       = prod_r;
    point_nxt      = point_r;
    run_nxt        = run_r;
    chosen_nxt     = chosen_r;
    req_nxt        = req_r;
    res_chosen_nxt = res_chosen_r;
    res_weight_nxt = res_weight_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_chosen_nxt = out_chosen_r;
    out_weight_nxt = out_weight_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = chosen_r;
    ram_wdata      = half_w;
    ram_raddr      = iss_cnt_r[IDX_W-1:0];

    // Issue one table read a cycle while scanning
    if (scan_state && (iss_cnt_r < n_eff)) begin
      iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
      rv_nxt      = 1'b1;
      ridx_nxt    = iss_cnt_r[IDX_W-1:0];
    end

    case (state_r)
      S_IDLE: begin
        ram_raddr = idx_ext[IDX_W-1:0];
        if (in_fire) begin
          req_nxt        = in_req_type;
          rnd_nxt        = in_random_fraction;
          res_chosen_nxt = '0;
          res_weight_nxt = '0;
          res_status_nxt = STAT_OK;
          state_nxt      = S_DONE;
          case (in_req_type)
            REQ_LOAD: begin
              if (idx_oor) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = idx_ext[IDX_W-1:0];
                ram_wdata = WEIGHT_BITS'(in_weight_value);
              end
            end
            REQ_READ: begin
              if (idx_oor) begin
                res_status_nxt = STAT_RANGE;
              end else begin
                state_nxt = S_RD;
              end
            end
            REQ_CHOOSE: begin
              if (n_eff == '0) begin
                res_status_nxt = STAT_EMPTY;
              end else if (weighted_mode_r) begin
                total_nxt   = '0;
                iss_cnt_nxt = '0;
                state_nxt   = S_SUM;
              end else begin
                total_nxt = TOT_W'(n_eff);
                state_nxt = S_MUL_LO;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_RD: begin
        res_weight_nxt = WEIGHT_IO_W'(ram_rdata);
        state_nxt      = S_DONE;
      end

      // Accumulate the total weight
      S_SUM: begin
        if (rv_r) begin
          total_nxt = total_r + TOT_W'(ram_rdata);
        end
        if (last_data) begin
          state_nxt = S_MUL_LO;
        end
      end

      S_MUL_LO: begin
        if (total_r == '0) begin
          res_status_nxt = STAT_EMPTY;
          state_nxt      = S_DONE;
        end else begin
          prod_nxt  = rnd_r * total_ext[RND_W-1:0];
          state_nxt = S_MUL_HI;
        end
      end

      S_MUL_HI: begin
        point_nxt = point_sum[TOT_W-1:0];
        if (weighted_mode_r) begin
          run_nxt     = '0;
          iss_cnt_nxt = '0;
          state_nxt   = S_SCAN;
        end else begin
          chosen_nxt     = point_sum[IDX_W-1:0];
          res_chosen_nxt = IDX_IN_W'(point_sum[IDX_W-1:0]);
          state_nxt      = dynamic_mode_r ? S_HALVE_RD : S_DONE;
        end
      end

      // Walk the running sum until it passes the point
      S_SCAN: begin
        if (rv_r) begin
          run_nxt = run_sum;
          if (point_r < run_sum) begin
            chosen_nxt     = ridx_r;
            res_chosen_nxt = IDX_IN_W'(ridx_r);
            rv_nxt         = 1'b0;
            state_nxt      = dynamic_mode_r ? S_HALVE_RD : S_DONE;
          end
        end
      end

      S_HALVE_RD: begin
        ram_raddr = chosen_r;
        state_nxt = S_HALVE_WR;
      end

      // Halve the chosen weight, start doubling if it ran low
      S_HALVE_WR: begin
        ram_we    = 1'b1;
        ram_waddr = chosen_r;
        ram_wdata = half_w;
        if (half_w <= WEIGHT_BITS'(LOW_LIMIT)) begin
          iss_cnt_nxt = '0;
          state_nxt   = S_DBL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Double every weight in use, saturating
      S_DBL: begin
        if (rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = ridx_r;
          ram_wdata = dbl_w;
        end
        if (last_data) begin
          state_nxt = S_DONE;
        end
      end

      // Hand the result to the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_chosen_nxt = res_chosen_r;
          out_weight_nxt = res_weight_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      rv_r            <= 1'b0;
      out_valid_r     <= 1'b0;
      item_count_r    <= '0;
      weighted_mode_r <= 1'b0;
      dynamic_mode_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rv_r        <= rv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ITEM_COUNT:    item_count_r    <= cfg_wdata[COUNT_W-1:0];
          CFG_WEIGHTED_MODE: weighted_mode_r <= cfg_wdata[0];
          CFG_DYNAMIC_MODE:  dynamic_mode_r  <= cfg_wdata[0];
          default: begin
            item_count_r <= item_count_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    iss_cnt_r    <= iss_cnt_nxt;
    ridx_r       <= ridx_nxt;
    rnd_r        <= rnd_nxt;
    total_r      <= total_nxt;
    prod_r       <= prod_nxt;
    point_r      <= point_nxt;
    run_r        <= run_nxt;
    chosen_r     <= chosen_nxt;
    req_r        <= req_nxt;
    res_chosen_r <= res_chosen_nxt;
    res_weight_r <= res_weight_nxt;
    res_status_r <= res_status_nxt;
    out_chosen_r <= out_chosen_nxt;
    out_weight_r <= out_weight_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_index = out_chosen_r;
  assign out_weight_out   = out_weight_r;
  assign out_status       = out_status_r;

  // Checks
  assign chk_read_only  = (state_r == S_SUM) || (state_r == S_SCAN);
  assign chk_pick_done  = (state_r == S_DONE) && (req_r == REQ_CHOOSE)
                          && (res_status_r == STAT_OK);
  assign chk_empty_req  = in_fire && (in_req_type == REQ_CHOOSE) && (n_eff == '0);
  assign chk_empty_done = (state_r == S_DONE) && (res_status_r == STAT_EMPTY);

  `WRS_CHECK(a_no_write_in_sum_scan, chk_read_only, !ram_we, "weight RAM written in scan")
  `WRS_CHECK(a_scale_nonzero_total, state_r == S_MUL_HI, total_r != '0, "zero total scaled")
  `WRS_CHECK(a_scan_index_in_use, rv_r, CNT_W'(ridx_r) < n_eff, "scan data beyond items")
  `WRS_CHECK(a_chosen_in_use, chk_pick_done, CNT_W'(chosen_r) < n_eff, "chosen beyond items")
  `WRS_CHECK_NEXT(a_empty_choose, chk_empty_req, chk_empty_done, "empty choose not flagged")

endmodule
